// ===== hdl/scrl_pkg.sv =====
// Shared types, codes and the CRC-8 step for the serial command/response link.
`default_nettype none

package scrl_pkg;

  localparam int NUM_DEVICES  = 16;
  localparam int REPLY_LENGTH = 11;
  localparam int DEV_AW       = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

  localparam logic [7:0] START_MARK  = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [2:0] MAX_PAYLOAD = 3'd5;
  // index of the reply CRC byte
  localparam logic [3:0] LAST_INDEX  = 4'(REPLY_LENGTH - 1);
  localparam logic [19:0] TIMEOUT_RESET = 20'd5000;

  localparam logic [1:0] ACT_SEND  = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_STATS = 2'd3;

  localparam logic [2:0] KIND_TX      = 3'd0;
  localparam logic [2:0] KIND_GOOD    = 3'd1;
  localparam logic [2:0] KIND_CRC_ERR = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_STATS   = 3'd4;

  localparam logic [1:0] CNT_SENT     = 2'd0;
  localparam logic [1:0] CNT_RECEIVED = 2'd1;
  localparam logic [1:0] CNT_CRC_ERR  = 2'd2;
  localparam logic [1:0] CNT_TIMEOUT  = 2'd3;

  typedef enum logic [2:0] {
    OP_TX,
    OP_GOOD,
    OP_CRC_ERR,
    OP_TIMEOUT,
    OP_STATS
  } op_t;

  typedef struct packed {
    logic [31:0] sent;
    logic [31:0] received;
    logic [31:0] crc_errors;
    logic [31:0] timeouts;
    logic [31:0] lat_last;
    logic [31:0] lat_avg;
    logic [31:0] lat_peak;
  } stats_word_t;

  typedef struct packed {
    logic [3:0]  rd_addr;
    logic        commit;
    op_t         op;
    logic [3:0]  addr;
    logic [31:0] elapsed;
  } stats_req_t;

  function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  localparam logic [7:0] START_CRC = crc_add(8'h00, START_MARK);

endpackage

`default_nettype wire

// ===== hdl/scrl_stats.sv =====
// Per-address counter and latency store: synchronous memory with read-modify-write.
`default_nettype none

module scrl_stats (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire scrl_pkg::stats_req_t  req,
  output scrl_pkg::stats_word_t      view
);

  scrl_pkg::stats_word_t mem [scrl_pkg::NUM_DEVICES];
  logic [scrl_pkg::NUM_DEVICES-1:0] seen;

  scrl_pkg::stats_word_t rd_word;
  scrl_pkg::stats_word_t fwd_word;
  scrl_pkg::stats_word_t cur;
  scrl_pkg::stats_word_t upd;
  logic                  rd_seen;
  logic                  fwd_hit;
  logic                  kept;
  logic                  we;
  logic [scrl_pkg::DEV_AW-1:0] ra;
  logic [scrl_pkg::DEV_AW-1:0] wa;
  logic [34:0]           avg_sum;

  assign ra   = req.rd_addr[scrl_pkg::DEV_AW-1:0];
  assign wa   = req.addr[scrl_pkg::DEV_AW-1:0];
  assign kept = {1'b0, req.addr} < 5'(scrl_pkg::NUM_DEVICES);
  assign we   = req.commit && kept && (req.op != scrl_pkg::OP_STATS);

  // entries never written read as zero; a write on the previous edge to the
  // entry just read is taken from the bypass register
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_word;
    end else if (rd_seen) begin
      cur = rd_word;
    end else begin
      cur = '0;
    end
  end

  // avg*8 - avg + new, kept to 35 bits
  assign avg_sum = {cur.lat_avg, 3'b000} - {3'b000, cur.lat_avg} + {3'b000, req.elapsed};

  always_comb begin
    upd = cur;
    case (req.op)
      scrl_pkg::OP_TX: begin
        upd.sent = cur.sent + 32'd1;
      end
      scrl_pkg::OP_GOOD: begin
        upd.received = cur.received + 32'd1;
        upd.lat_last = req.elapsed;
        upd.lat_avg  = avg_sum[34:3];
        if (req.elapsed > cur.lat_peak) begin
          upd.lat_peak = req.elapsed;
        end
      end
      scrl_pkg::OP_CRC_ERR: begin
        upd.crc_errors = cur.crc_errors + 32'd1;
      end
      scrl_pkg::OP_TIMEOUT: begin
        upd.timeouts = cur.timeouts + 32'd1;
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  always_comb begin
    if (!kept) begin
      view = '0;
    end else if (req.op == scrl_pkg::OP_STATS) begin
      view = cur;
    end else begin
      view = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= upd;
    end
    rd_word  <= mem[ra];
    fwd_word <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= '0;
      rd_seen <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (we) begin
        seen[wa] <= 1'b1;
      end
      rd_seen <= seen[ra];
      fwd_hit <= we && (wa == ra);
    end
  end

  a_seen_after_write: assert property (@(posedge clk) disable iff (rst)
    we |=> seen[$past(wa)])
    else $error("written entry not marked valid");

  a_bypass_needs_write: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(we) && $past(req.commit))
    else $error("bypass taken without a preceding write");

endmodule

`default_nettype wire

// ===== hdl/serial_command_response_link_top.sv =====
// Top level: link control, request staging, statistics store and result emitter.
//
//  channel | handshake                  | carries
//  --------+----------------------------+-------------------------------------------
//  in      | in_valid / in_stall        | action, address, command, payload, length, rx
//  out     | out_valid / out_stall      | kind, tx_data, last, address, reply, stats
//  cfg     | cfg_write_enable           | cfg_write_data -> timeout_ticks
//
//  A request is registered in the request stage, then in the emitter.
//  Results hold while out_stall is high; a no-result request emits nothing.
//  The next request is taken while the previous one's results drain, set by
//  the single stage in front of the emitter and the stats memory read port.
//  Reset: link state cleared, timeout_ticks = 5000, stats read as zero via
//  per-address valid bits (no clearing pass).
`default_nettype none

module serial_command_response_link_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_enable,
  input  wire logic [19:0]        cfg_write_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [3:0]         address,
  input  wire logic [3:0]         command,
  input  wire logic [39:0]        payload,
  input  wire logic [2:0]         payload_length,
  input  wire logic [7:0]         rx_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              kind,
  output logic [7:0]              tx_data,
  output logic                    last,
  output logic [3:0]              reply_address,
  output logic [7:0]              device_status,
  output logic signed [31:0]      position,
  output logic signed [31:0]      velocity,
  output logic [31:0]             latency_last,
  output logic [31:0]             latency_average,
  output logic [31:0]             latency_peak,
  output logic [1:0]              counter_id,
  output logic [31:0]             counter_value
);

  // link state
  logic [19:0] timeout_ticks;
  logic        awaiting;
  logic [3:0]  pending_address;
  logic [3:0]  reply_index;
  logic [7:0]  reply_crc;
  logic [7:0]  reply_bytes [10];
  logic [31:0] elapsed_ticks;

  // staged request
  logic            s1_valid;
  scrl_pkg::op_t   s1_op;
  logic [3:0]      s1_addr;
  logic [3:0]      s1_cmd;
  logic [39:0]     s1_payload;
  logic [2:0]      s1_plen;
  logic [7:0]      s1_status;
  logic [31:0]     s1_pos;
  logic [31:0]     s1_vel;
  logic [31:0]     s1_elapsed;

  // result emitter
  logic                  e_valid;
  scrl_pkg::op_t         e_op;
  logic [2:0]            e_idx;
  logic [3:0]            e_addr;
  logic [3:0]            e_cmd;
  logic [39:0]           e_payload;
  logic [2:0]            e_plen;
  logic [7:0]            e_crc;
  logic [7:0]            e_status;
  logic [31:0]           e_pos;
  logic [31:0]           e_vel;
  scrl_pkg::stats_word_t e_stats;
  logic                  e_last;

  logic                  in_fire;
  logic                  out_fire;
  logic                  s1_adv;
  logic                  item_has;
  scrl_pkg::op_t         item_op;
  logic [3:0]            item_addr;
  logic [7:0]            crc_next;
  logic [31:0]           elapsed_inc;
  logic                  timed_out;
  logic [2:0]            plen_sat;
  logic [2:0]            pick;
  scrl_pkg::stats_req_t  sreq;
  scrl_pkg::stats_word_t sview;

  assign in_fire   = in_valid && !in_stall;
  assign out_valid = e_valid;
  assign out_fire  = e_valid && !out_stall;
  assign s1_adv    = s1_valid && (!e_valid || (out_fire && e_last));
  assign in_stall  = s1_valid && !s1_adv;

  assign crc_next    = scrl_pkg::crc_add(reply_crc, rx_data);
  assign elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 32'd1;
  assign timed_out   = elapsed_inc >= {12'b0, timeout_ticks};
  assign plen_sat    = (payload_length > scrl_pkg::MAX_PAYLOAD) ? scrl_pkg::MAX_PAYLOAD
                                                                : payload_length;

  always_comb begin
    item_has  = 1'b0;
    item_op   = scrl_pkg::OP_STATS;
    item_addr = address;
    case (action)
      scrl_pkg::ACT_SEND: begin
        if (!awaiting) begin
          item_has = 1'b1;
          item_op  = scrl_pkg::OP_TX;
        end
      end
      scrl_pkg::ACT_BYTE: begin
        item_addr = pending_address;
        if (awaiting && rx_data != scrl_pkg::START_MARK &&
            reply_index == scrl_pkg::LAST_INDEX) begin
          item_has = 1'b1;
          item_op  = (rx_data == reply_crc) ? scrl_pkg::OP_GOOD : scrl_pkg::OP_CRC_ERR;
        end
      end
      scrl_pkg::ACT_TICK: begin
        item_addr = pending_address;
        if (awaiting && timed_out) begin
          item_has = 1'b1;
          item_op  = scrl_pkg::OP_TIMEOUT;
        end
      end
      default: begin
        item_has = 1'b1;
        item_op  = scrl_pkg::OP_STATS;
      end
    endcase
  end

  // link control
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= scrl_pkg::TIMEOUT_RESET;
      awaiting        <= 1'b0;
      pending_address <= '0;
      reply_index     <= '0;
      reply_crc       <= '0;
      elapsed_ticks   <= '0;
    end else begin
      if (cfg_write_enable) begin
        timeout_ticks <= cfg_write_data;
      end
      if (in_fire) begin
        case (action)
          scrl_pkg::ACT_SEND: begin
            if (!awaiting) begin
              awaiting        <= 1'b1;
              pending_address <= address;
              reply_index     <= '0;
              reply_crc       <= '0;
              elapsed_ticks   <= '0;
            end
          end
          scrl_pkg::ACT_BYTE: begin
            if (awaiting) begin
              if (rx_data == scrl_pkg::START_MARK) begin
                reply_crc   <= scrl_pkg::START_CRC;
                reply_index <= 4'd1;
              end else if (reply_index != '0) begin
                if (reply_index < scrl_pkg::LAST_INDEX) begin
                  reply_crc   <= crc_next;
                  reply_index <= reply_index + 4'd1;
                end else begin
                  awaiting    <= 1'b0;
                  reply_index <= '0;
                end
              end
            end
          end
          scrl_pkg::ACT_TICK: begin
            if (awaiting) begin
              elapsed_ticks <= elapsed_inc;
              if (timed_out) begin
                awaiting    <= 1'b0;
                reply_index <= '0;
              end
            end
          end
          default: begin
            awaiting <= awaiting;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && action == scrl_pkg::ACT_BYTE && awaiting) begin
      if (rx_data == scrl_pkg::START_MARK) begin
        reply_bytes[0] <= rx_data;
      end else if (reply_index != '0 && reply_index < scrl_pkg::LAST_INDEX) begin
        reply_bytes[reply_index] <= rx_data;
      end
    end
  end

  // request stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= item_has;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && item_has) begin
      s1_op      <= item_op;
      s1_addr    <= item_addr;
      s1_cmd     <= command;
      s1_payload <= payload;
      s1_plen    <= plen_sat;
      s1_status  <= reply_bytes[1];
      s1_pos     <= {reply_bytes[5], reply_bytes[4], reply_bytes[3], reply_bytes[2]};
      s1_vel     <= {reply_bytes[9], reply_bytes[8], reply_bytes[7], reply_bytes[6]};
      s1_elapsed <= elapsed_ticks;
    end
  end

  // a held request keeps re-reading its own entry
  always_comb begin
    sreq.rd_addr = in_stall ? s1_addr : item_addr;
    sreq.commit  = s1_adv;
    sreq.op      = s1_op;
    sreq.addr    = s1_addr;
    sreq.elapsed = s1_elapsed;
  end

  scrl_stats u_stats (
    .clk  (clk),
    .rst  (rst),
    .req  (sreq),
    .view (sview)
  );

  // result emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (s1_adv) begin
      e_valid <= 1'b1;
    end else if (out_fire && e_last) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      e_idx <= '0;
      e_crc <= '0;
    end else if (out_fire) begin
      e_idx <= e_idx + 3'd1;
      if (e_op == scrl_pkg::OP_TX) begin
        e_crc <= scrl_pkg::crc_add(e_crc, tx_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      e_op      <= s1_op;
      e_addr    <= s1_addr;
      e_cmd     <= s1_cmd;
      e_payload <= s1_payload;
      e_plen    <= s1_plen;
      if (s1_op == scrl_pkg::OP_GOOD) begin
        e_status <= s1_status;
        e_pos    <= s1_pos;
        e_vel    <= s1_vel;
      end else begin
        e_status <= '0;
        e_pos    <= '0;
        e_vel    <= '0;
      end
      if (s1_op == scrl_pkg::OP_GOOD || s1_op == scrl_pkg::OP_STATS) begin
        e_stats <= sview;
      end else begin
        e_stats <= '0;
      end
    end
  end

  always_comb begin
    case (e_op)
      scrl_pkg::OP_TX:    e_last = (e_idx == e_plen + 3'd2);
      scrl_pkg::OP_STATS: e_last = (e_idx[1:0] == scrl_pkg::CNT_TIMEOUT);
      default:            e_last = 1'b1;
    endcase
  end

  assign pick = e_idx - 3'd2;

  always_comb begin
    tx_data = '0;
    if (e_op == scrl_pkg::OP_TX) begin
      if (e_idx == 3'd0) begin
        tx_data = scrl_pkg::START_MARK;
      end else if (e_idx == 3'd1) begin
        tx_data = {e_addr, e_cmd};
      end else if (pick < e_plen) begin
        case (pick)
          3'd0:    tx_data = e_payload[7:0];
          3'd1:    tx_data = e_payload[15:8];
          3'd2:    tx_data = e_payload[23:16];
          3'd3:    tx_data = e_payload[31:24];
          3'd4:    tx_data = e_payload[39:32];
          default: tx_data = '0;
        endcase
      end else begin
        tx_data = e_crc;
      end
    end
  end

  always_comb begin
    case (e_op)
      scrl_pkg::OP_TX:      kind = scrl_pkg::KIND_TX;
      scrl_pkg::OP_GOOD:    kind = scrl_pkg::KIND_GOOD;
      scrl_pkg::OP_CRC_ERR: kind = scrl_pkg::KIND_CRC_ERR;
      scrl_pkg::OP_TIMEOUT: kind = scrl_pkg::KIND_TIMEOUT;
      default:              kind = scrl_pkg::KIND_STATS;
    endcase
  end

  always_comb begin
    counter_id    = '0;
    counter_value = '0;
    if (e_op == scrl_pkg::OP_STATS) begin
      counter_id = e_idx[1:0];
      case (e_idx[1:0])
        scrl_pkg::CNT_SENT:     counter_value = e_stats.sent;
        scrl_pkg::CNT_RECEIVED: counter_value = e_stats.received;
        scrl_pkg::CNT_CRC_ERR:  counter_value = e_stats.crc_errors;
        default:                counter_value = e_stats.timeouts;
      endcase
    end
  end

  assign last            = e_last;
  assign reply_address   = e_addr;
  assign device_status   = e_status;
  assign position        = e_pos;
  assign velocity        = e_vel;
  assign latency_last    = e_stats.lat_last;
  assign latency_average = e_stats.lat_avg;
  assign latency_peak    = e_stats.lat_peak;

  a_idle_no_reply: assert property (@(posedge clk) disable iff (rst)
    !awaiting |-> reply_index == '0)
    else $error("reply in progress while not awaiting");

  a_reply_index_range: assert property (@(posedge clk) disable iff (rst)
    reply_index <= scrl_pkg::LAST_INDEX)
    else $error("reply index past CRC byte");

  a_frame_no_overrun: assert property (@(posedge clk) disable iff (rst)
    e_valid && e_op == scrl_pkg::OP_TX |-> e_idx <= e_plen + 3'd2)
    else $error("frame emitter ran past CRC byte");

  a_emitter_restart: assert property (@(posedge clk) disable iff (rst)
    out_fire && e_last |=> !e_valid || e_idx == '0)
    else $error("emitter did not restart after last result");

endmodule

`default_nettype wire
